// ----- sv/tgvt_pkg.sv -----
// ----------------------------------------------------------------------------
// tgvt_pkg
// Shared types and constants of the two-gate velocity timer: item layouts,
// configuration register set, reset values and field limits.
// ----------------------------------------------------------------------------
package tgvt_pkg;

    localparam int CAL_SAMPLES_DEF = 20;
    localparam int TICK_WIDTH_DEF  = 32;

    localparam int SAMPLE_W = 10;
    localparam int TPM_W    = 16;
    localparam int DIST_W   = 10;
    localparam int MS_W     = 30;
    localparam int VEL_W    = 20;
    localparam int PROD_W   = 20;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [TPM_W-1:0]  TPM_RESET  = 16'd4000;
    localparam logic [DIST_W-1:0] DIST_RESET = 10'd23;
    localparam logic [DIST_W-1:0] MS_PER_S   = 10'd1000;
    localparam logic [MS_W-1:0]   MS_MAX     = '1;
    localparam logic [VEL_W-1:0]  VEL_MAX    = '1;

    // register index taken from paddr[2]
    localparam logic REG_TPM  = 1'b0;
    localparam logic REG_DIST = 1'b1;

    localparam logic EV_CAL  = 1'b0;
    localparam logic EV_SHOT = 1'b1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] front_sample;
        logic [SAMPLE_W-1:0] back_sample;
        logic                button;
    } t_in_item;

    typedef struct packed {
        logic                event_kind;
        logic [SAMPLE_W-1:0] front_threshold_out;
        logic [SAMPLE_W-1:0] back_threshold_out;
        logic [MS_W-1:0]     elapsed_ms;
        logic [VEL_W-1:0]    velocity_cm_s;
        logic                zero_time;
    } t_out_item;

    typedef struct packed {
        logic [TPM_W-1:0]  ticks_per_ms;
        logic [DIST_W-1:0] gate_distance_cm;
    } t_cfg;

endpackage

// ----- sv/tgvt_div.sv -----
// ----------------------------------------------------------------------------
// tgvt_div
// Shared restoring divider: one quotient bit per cycle while busy, done pulses
// for one cycle with the quotient held afterwards.
// ----------------------------------------------------------------------------
module tgvt_div #(
    parameter int DW = 32,
    parameter int VW = 30
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;
    logic [DW-1:0] r_quo;

    logic [VW:0]   w_sh;
    logic [VW:0]   w_diff;
    logic          w_ge;

    assign w_sh   = {r_rem, r_quo[DW-1]};
    assign w_ge   = (w_sh >= {1'b0, r_div});
    assign w_diff = w_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out of the top of r_quo while quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[VW-1:0] : w_sh[VW-1:0];
            r_quo <= {r_quo[DW-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- sv/tgvt_apb.sv -----
// ----------------------------------------------------------------------------
// tgvt_apb
// Configuration register file behind an APB-style slave port: ticks per
// millisecond at 0x0, gate distance at 0x4. Zero wait states.
// ----------------------------------------------------------------------------
module tgvt_apb (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tgvt_pkg::ADDR_W-1:0] paddr,
    input  logic [tgvt_pkg::DATA_W-1:0] pwdata,
    output logic [tgvt_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output tgvt_pkg::t_cfg             o_cfg
);
    import tgvt_pkg::*;

    logic [TPM_W-1:0]  r_tpm;
    logic [DIST_W-1:0] r_dist;
    logic              w_wr;

    assign w_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpm  <= TPM_RESET;
            r_dist <= DIST_RESET;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_TPM:  r_tpm  <= pwdata[TPM_W-1:0];
                REG_DIST: r_dist <= pwdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TPM:  prdata = DATA_W'(r_tpm);
            REG_DIST: prdata = DATA_W'(r_dist);
            default:  prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign o_cfg  = '{ticks_per_ms: r_tpm, gate_distance_cm: r_dist};

endmodule

// ----- sv/two_gate_velocity_timer.sv -----
// ----------------------------------------------------------------------------
// two_gate_velocity_timer
// Light-gate chronograph: calibrates sensor thresholds, times the passage
// between the front and back gates and reports elapsed time and velocity.
//
// Usage:
//   One input transfer per timer tick carries both sensor samples and the
//   button level. Ticks that produce no result (calibration sums, arming,
//   counting, waiting) keep o_in_ready high and a tick can follow every cycle.
//   The tick that completes calibration runs two divisions by
//   CAL_SAMPLES+1; the tick that sees the back gate runs ticks/ticks_per_ms
//   and then distance*1000/ms. Each division uses the single shared
//   restoring divider of width DW = max(TICK_WIDTH, 30), and these ticks
//   hold o_in_ready low until their result is emitted; a shot with zero
//   milliseconds skips the second division.
//   The result sits in an output register; while the receiver stalls,
//   later non-result ticks are still taken, and a new result waits in the
//   emit step, with o_in_ready low, until the register frees up.
//   Reset clears the state to calibrating, zeroes sums, thresholds and the
//   tick counter, and loads ticks_per_ms = 4000, gate_distance_cm = 23.
//   Write the registers over the APB port only while the block is idle.
// ----------------------------------------------------------------------------
module two_gate_velocity_timer #(
    parameter int CAL_SAMPLES = tgvt_pkg::CAL_SAMPLES_DEF,
    parameter int TICK_WIDTH  = tgvt_pkg::TICK_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  tgvt_pkg::t_in_item          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output tgvt_pkg::t_out_item         o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tgvt_pkg::ADDR_W-1:0] paddr,
    input  logic [tgvt_pkg::DATA_W-1:0] pwdata,
    output logic [tgvt_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import tgvt_pkg::*;

    localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
    localparam int SUM_W = SAMPLE_W + CNT_W;
    localparam int DW    = (TICK_WIDTH > MS_W) ? TICK_WIDTH : MS_W;
    localparam int VW    = MS_W;

    localparam logic [1:0] PH_CAL   = 2'd0;
    localparam logic [1:0] PH_ARMED = 2'd1;
    localparam logic [1:0] PH_TIME  = 2'd2;
    localparam logic [1:0] PH_WAIT  = 2'd3;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CALF = 3'd1;
    localparam logic [2:0] S_CALB = 3'd2;
    localparam logic [2:0] S_MS   = 3'd3;
    localparam logic [2:0] S_VEL  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    t_cfg                  w_cfg;
    logic                  w_acc;
    logic                  w_out_free;
    logic                  w_div_done;
    logic [DW-1:0]         w_quo;
    logic [SUM_W-1:0]      w_fsum;
    logic [SUM_W-1:0]      w_bsum;
    logic [CNT_W-1:0]      w_cnt;
    logic [TICK_WIDTH-1:0] w_tick;
    logic [VW-1:0]         w_tpm_div;
    logic [MS_W-1:0]       w_ms;
    logic [VEL_W-1:0]      w_vel;
    logic                  n_start;

    logic [2:0]            r_state;
    logic [1:0]            r_phase;
    logic [CNT_W-1:0]      r_cal_cnt;
    logic [SUM_W-1:0]      r_fsum;
    logic [SUM_W-1:0]      r_bsum;
    logic [SAMPLE_W-1:0]   r_fthr;
    logic [SAMPLE_W-1:0]   r_bthr;
    logic [TICK_WIDTH-1:0] r_tick;
    logic                  r_start;
    logic                  r_out_valid;
    logic [DW-1:0]         r_dividend;
    logic [VW-1:0]         r_divisor;
    logic [PROD_W-1:0]     r_prod;
    logic                  r_kind;
    logic [MS_W-1:0]       r_ms;
    logic [VEL_W-1:0]      r_vel;
    logic                  r_zero;
    t_out_item             r_out;

    tgvt_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tgvt_div #(.DW(DW), .VW(VW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_dividend (r_dividend),
        .i_divisor  (r_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_fsum    = r_fsum + SUM_W'(i_in_data.front_sample);
    assign w_bsum    = r_bsum + SUM_W'(i_in_data.back_sample);
    assign w_cnt     = r_cal_cnt + 1'b1;
    assign w_tick    = (r_tick == '1) ? r_tick : r_tick + 1'b1;
    assign w_tpm_div = (w_cfg.ticks_per_ms == '0) ? VW'(1) : VW'(w_cfg.ticks_per_ms);
    assign w_ms      = (w_quo > DW'(MS_MAX)) ? MS_MAX : w_quo[MS_W-1:0];
    assign w_vel     = (w_quo > DW'(VEL_MAX)) ? VEL_MAX : w_quo[VEL_W-1:0];

    // kick the divider on the step that hands it new operands
    always_comb begin
        n_start = 1'b0;
        unique case (r_state)
            S_IDLE: n_start = w_acc &&
                              ((r_phase == PH_CAL && w_cnt == CNT_W'(CAL_SAMPLES)) ||
                               (r_phase == PH_TIME &&
                                i_in_data.back_sample < r_bthr));
            S_CALF: n_start = w_div_done;
            S_MS:   n_start = w_div_done && (w_ms != '0);
            default: n_start = 1'b0;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_CAL;
            r_cal_cnt   <= '0;
            r_fsum      <= '0;
            r_bsum      <= '0;
            r_fthr      <= '0;
            r_bthr      <= '0;
            r_tick      <= '0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= n_start;
            if (r_state == S_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        unique case (r_phase)
                            PH_CAL: begin
                                r_fsum    <= w_fsum;
                                r_bsum    <= w_bsum;
                                r_cal_cnt <= w_cnt;
                                if (w_cnt == CNT_W'(CAL_SAMPLES)) begin
                                    r_phase <= PH_ARMED;
                                    r_state <= S_CALF;
                                end
                            end
                            PH_ARMED: begin
                                if (i_in_data.front_sample < r_fthr) begin
                                    r_tick  <= '0;
                                    r_phase <= PH_TIME;
                                end
                            end
                            PH_TIME: begin
                                r_tick <= w_tick;
                                if (i_in_data.back_sample < r_bthr) begin
                                    r_phase <= PH_WAIT;
                                    r_state <= S_MS;
                                end
                            end
                            PH_WAIT: begin
                                if (i_in_data.button) begin
                                    r_tick  <= '0;
                                    r_phase <= PH_ARMED;
                                end
                            end
                            default: r_phase <= PH_ARMED;
                        endcase
                    end
                end
                S_CALF: begin
                    if (w_div_done) begin
                        r_fthr  <= w_quo[SAMPLE_W-1:0];
                        r_state <= S_CALB;
                    end
                end
                S_CALB: begin
                    if (w_div_done) begin
                        r_bthr  <= w_quo[SAMPLE_W-1:0];
                        r_state <= S_EMIT;
                    end
                end
                S_MS: begin
                    if (w_div_done) begin
                        if (w_ms == '0) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_VEL;
                        end
                    end
                end
                S_VEL: begin
                    if (w_div_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // hold until the output register frees up
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // divider operands and result payload
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(w_cfg.gate_distance_cm) * PROD_W'(MS_PER_S);
        unique case (r_state)
            S_IDLE: begin
                if (w_acc && r_phase == PH_CAL) begin
                    r_dividend <= DW'(w_fsum);
                    r_divisor  <= VW'(CAL_SAMPLES + 1);
                    r_kind     <= EV_CAL;
                    r_ms       <= '0;
                    r_vel      <= '0;
                    r_zero     <= 1'b0;
                end else if (w_acc && r_phase == PH_TIME) begin
                    r_dividend <= DW'(w_tick);
                    r_divisor  <= w_tpm_div;
                    r_kind     <= EV_SHOT;
                end
            end
            S_CALF: begin
                if (w_div_done) begin
                    r_dividend <= DW'(r_bsum);
                end
            end
            S_MS: begin
                if (w_div_done) begin
                    r_ms       <= w_ms;
                    r_zero     <= (w_ms == '0);
                    r_vel      <= VEL_MAX;
                    r_dividend <= DW'(r_prod);
                    r_divisor  <= w_ms;
                end
            end
            S_VEL: begin
                if (w_div_done) begin
                    r_vel <= w_vel;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    r_out <= '{event_kind:          r_kind,
                               front_threshold_out: r_fthr,
                               back_threshold_out:  r_bthr,
                               elapsed_ms:          r_ms,
                               velocity_cm_s:       r_vel,
                               zero_time:           r_zero};
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- sv/tgvt_chk.sv -----
// ----------------------------------------------------------------------------
// tgvt_chk
// Port-level checks of the two-gate velocity timer: result consistency and
// output hold under stall. Bound to the top level.
// ----------------------------------------------------------------------------
module tgvt_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input tgvt_pkg::t_out_item         o_out_data
);
    import tgvt_pkg::*;

    // stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or dropped while stalled");

    // calibration report carries no timing figures
    a_cal_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.event_kind == EV_CAL |->
            o_out_data.elapsed_ms == '0 && o_out_data.velocity_cm_s == '0 &&
            !o_out_data.zero_time)
        else $error("calibration report with timing fields set");

    // zero time only on shots, with saturated velocity
    a_zero_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.zero_time |->
            o_out_data.event_kind == EV_SHOT && o_out_data.velocity_cm_s == VEL_MAX &&
            o_out_data.elapsed_ms == '0)
        else $error("zero time without saturated velocity");

    // a shot with nonzero time reports nonzero milliseconds
    a_shot_ms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.event_kind == EV_SHOT && !o_out_data.zero_time |->
            o_out_data.elapsed_ms != '0)
        else $error("shot with zero milliseconds not flagged");

endmodule

bind two_gate_velocity_timer tgvt_chk u_tgvt_chk (.*);
